// File: sv/ycc2rgb_pkg.sv
`timescale 1ns / 1ps

package ycc2rgb_pkg;

    localparam int BaseW = 26;
    localparam int SumW  = 28;

    localparam logic signed [SumW-1:0] CoefCrR = 28'sd104597;
    localparam logic signed [SumW-1:0] CoefCbB = 28'sd132201;
    localparam logic signed [SumW-1:0] CoefCbG = 28'sd25675;
    localparam logic signed [SumW-1:0] CoefCrG = 28'sd53279;

    localparam longint LumaOffset = 16;
    localparam longint LumaNum    = 255;
    localparam longint LumaDen    = 219;
    localparam longint QOne       = 65536;
    localparam longint QHalf      = 32768;
    localparam longint LumaDiv    = 2 * LumaDen;
    localparam longint LumaLift   = 2097152;

    localparam logic REG_PIXEL_FORMAT = 1'b0;

    typedef enum logic [1:0] {
        FMT_RGB565 = 2'd0,
        FMT_RGB555 = 2'd1,
        FMT_RGB24  = 2'd2,
        FMT_XRGB32 = 2'd3
    } t_pixel_format;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] packed_pixel;
    } t_pixel_out;

    typedef struct packed {
        logic signed [BaseW-1:0] base;
        logic signed [SumW-1:0]  red_term;
        logic signed [SumW-1:0]  green_cb_term;
        logic signed [SumW-1:0]  green_cr_term;
        logic signed [SumW-1:0]  blue_term;
    } t_products;

    typedef struct packed {
        logic signed [SumW-1:0] red;
        logic signed [SumW-1:0] green;
        logic signed [SumW-1:0] blue;
    } t_sums;

    typedef logic signed [BaseW-1:0] t_luma_lut [256];

    // Scaled luma with the rounding half already folded in.
    // The numerator is lifted by a whole multiple of the divisor so that it is never negative,
    // and the floor of the quotient is then found by shift and subtract.
    function automatic t_luma_lut f_build_luma_lut();
        t_luma_lut lut;
        longint    twice;
        longint    rem;
        longint    quot;
        for (int i = 0; i < 256; i++) begin
            twice = 2 * (longint'(i) - LumaOffset) * LumaNum * QOne + LumaDen
                    + LumaLift * LumaDiv;
            rem  = 0;
            quot = 0;
            for (int b = 35; b >= 0; b--) begin
                rem  = (rem << 1) | ((twice >> b) & 1);
                quot = quot << 1;
                if (rem >= LumaDiv) begin
                    rem  = rem - LumaDiv;
                    quot = quot | 1;
                end
            end
            lut[i] = BaseW'(quot - LumaLift + QHalf);
        end
        return lut;
    endfunction

    localparam t_luma_lut LumaLut = f_build_luma_lut();

endpackage

// File: sv/ycbcr_to_rgb_pixel_converter_core.sv
`timescale 1ns / 1ps

// Converts one video-range BT.601 pixel (Y, Cb, Cr) per clock into clipped 8-bit R, G and B
// and a packed word in the format held in the pixel_format register (RGB565, RGB555, or
// 24-bit RGB, which the 32-bit xRGB setting also gives). busy never rises, so a beat may be
// started in every cycle. Each result appears on o_result for a single cycle with
// o_result_valid high; the receiver cannot stall it and must take it then. Each beat is
// registered in turn through the pipeline: luma table and chroma centring, the four
// coefficient multipliers, the channel sums, then clipping and packing. pixel_format sits
// at byte address 0 of the APB port and is only to be changed while no beat is in flight.

module ycbcr_to_rgb_pixel_converter_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ycc2rgb_pkg::t_pixel_in  i_pixel,
    output logic                    o_result_valid,
    output ycc2rgb_pkg::t_pixel_out o_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import ycc2rgb_pkg::*;

    t_pixel_format r_pixel_format;
    logic          w_accept;
    logic          w_prod_valid;
    t_products     w_products;
    logic          w_sum_valid;
    t_sums         w_sums;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= FMT_RGB565;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_FORMAT) begin
            r_pixel_format <= t_pixel_format'(pwdata[1:0]);
        end
    end

    always_comb begin
        if (paddr[2] == REG_PIXEL_FORMAT) begin
            prdata = {30'd0, r_pixel_format};
        end else begin
            prdata = 32'd0;
        end
    end

    ycc2rgb_prod u_prod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_pixel    (i_pixel),
        .o_valid    (w_prod_valid),
        .o_products (w_products)
    );

    ycc2rgb_sum u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_prod_valid),
        .i_products (w_products),
        .o_valid    (w_sum_valid),
        .o_sums     (w_sums)
    );

    ycc2rgb_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sum_valid),
        .i_sums   (w_sums),
        .i_format (r_pixel_format),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_accept |-> ##4 o_result_valid)
        else $error("accepted beat did not produce a result four cycles later");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_accept, 4))
        else $error("result produced without an accepted beat");

    a_short_format : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (r_pixel_format == FMT_RGB565 || r_pixel_format == FMT_RGB555)
        |-> o_result.packed_pixel[23:16] == 8'd0)
        else $error("16-bit packing left high bits set");

    a_wide_format : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (r_pixel_format == FMT_RGB24 || r_pixel_format == FMT_XRGB32)
        |-> o_result.packed_pixel == {o_result.red, o_result.green, o_result.blue})
        else $error("24-bit packing disagrees with the components");

endmodule

// File: sv/ycc2rgb_prod.sv
`timescale 1ns / 1ps

module ycc2rgb_prod (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  ycc2rgb_pkg::t_pixel_in i_pixel,
    output logic                   o_valid,
    output ycc2rgb_pkg::t_products o_products
);
    import ycc2rgb_pkg::*;

    logic                    r_v1;
    logic signed [BaseW-1:0] r_base1;
    logic signed [7:0]       r_cb1;
    logic signed [7:0]       r_cr1;
    logic                    r_v2;
    t_products               r_prod;
    t_products               n_prod;
    logic signed [SumW-1:0]  w_cb;
    logic signed [SumW-1:0]  w_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Centring at 128 is a flip of the top bit.
    always_ff @(posedge i_clk) begin
        r_base1 <= LumaLut[i_pixel.luma];
        r_cb1   <= $signed({~i_pixel.chroma_blue[7], i_pixel.chroma_blue[6:0]});
        r_cr1   <= $signed({~i_pixel.chroma_red[7], i_pixel.chroma_red[6:0]});
    end

    assign w_cb = SumW'(r_cb1);
    assign w_cr = SumW'(r_cr1);

    always_comb begin
        n_prod.base          = r_base1;
        n_prod.red_term      = w_cr * CoefCrR;
        n_prod.green_cb_term = w_cb * CoefCbG;
        n_prod.green_cr_term = w_cr * CoefCrG;
        n_prod.blue_term     = w_cb * CoefCbB;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_valid    = r_v2;
    assign o_products = r_prod;

endmodule

// File: sv/ycc2rgb_sum.sv
`timescale 1ns / 1ps

module ycc2rgb_sum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  ycc2rgb_pkg::t_products i_products,
    output logic                   o_valid,
    output ycc2rgb_pkg::t_sums     o_sums
);
    import ycc2rgb_pkg::*;

    logic                   r_valid;
    t_sums                  r_sums;
    t_sums                  n_sums;
    logic signed [SumW-1:0] w_base;

    assign w_base = SumW'(i_products.base);

    always_comb begin
        n_sums.red   = w_base + i_products.red_term;
        n_sums.green = w_base - i_products.green_cb_term - i_products.green_cr_term;
        n_sums.blue  = w_base + i_products.blue_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sums <= n_sums;
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;

endmodule

// File: sv/ycc2rgb_pack.sv
`timescale 1ns / 1ps

module ycc2rgb_pack (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  ycc2rgb_pkg::t_sums         i_sums,
    input  ycc2rgb_pkg::t_pixel_format i_format,
    output logic                       o_valid,
    output ycc2rgb_pkg::t_pixel_out    o_result
);
    import ycc2rgb_pkg::*;

    logic       r_valid;
    t_pixel_out r_result;
    t_pixel_out n_result;
    logic [7:0] w_red;
    logic [7:0] w_green;
    logic [7:0] w_blue;

    function automatic logic [7:0] f_clip(input logic signed [SumW-1:0] s);
        logic [7:0] v;
        if (s[SumW-1]) begin
            v = 8'd0;
        end else if (|s[SumW-2:24]) begin
            v = 8'hFF;
        end else begin
            v = s[23:16];
        end
        return v;
    endfunction

    assign w_red   = f_clip(i_sums.red);
    assign w_green = f_clip(i_sums.green);
    assign w_blue  = f_clip(i_sums.blue);

    always_comb begin
        n_result.red   = w_red;
        n_result.green = w_green;
        n_result.blue  = w_blue;
        case (i_format)
            FMT_RGB565: begin
                n_result.packed_pixel = {8'd0, w_red[7:3], w_green[7:2], w_blue[7:3]};
            end
            FMT_RGB555: begin
                n_result.packed_pixel = {9'd0, w_red[7:3], w_green[7:3], w_blue[7:3]};
            end
            default: begin
                n_result.packed_pixel = {w_red, w_green, w_blue};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: tb/tb_ycbcr_to_rgb_pixel_converter_core.sv
`timescale 1ns / 1ps

module tb_ycbcr_to_rgb_pixel_converter_core;

    import ycc2rgb_pkg::*;

    localparam longint CR_TO_RED   = 104597;
    localparam longint CB_TO_BLUE  = 132201;
    localparam longint CB_TO_GREEN = 25675;
    localparam longint CR_TO_GREEN = 53279;
    localparam longint Q16_ONE     = 65536;
    localparam longint Q16_HALF    = 32768;
    localparam longint BLACK_LEVEL = 16;
    localparam longint CHROMA_MID  = 128;
    localparam longint LUMA_SPAN   = 219;
    localparam longint FULL_SCALE  = 255;

    localparam logic REG_SPARE  = 1'b1;
    localparam int   IDLE_LIMIT = 1000;
    localparam int   PIPE_DEPTH = 4;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_pixel_in   i_pixel = '0;
    logic        o_result_valid;
    t_pixel_out  o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_pixel_out    pending_rgb[$];
    t_pixel_format cur_format = FMT_RGB565;
    bit            gaps_on = 1'b1;
    int            errors = 0;
    int            pixels_sent = 0;
    int            results_checked = 0;
    int            format_pixels[4] = '{0, 0, 0, 0};
    int            idle_cycles = 0;

    ycbcr_to_rgb_pixel_converter_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel        (i_pixel),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint scaled_luma(input logic [7:0] y);
        longint num;
        longint quot;
        num  = 2 * (longint'(y) - BLACK_LEVEL) * FULL_SCALE * Q16_ONE + LUMA_SPAN;
        quot = num / (2 * LUMA_SPAN);
        if (num < 0 && quot * (2 * LUMA_SPAN) != num) begin
            quot = quot - 1;
        end
        return quot;
    endfunction

    function automatic logic [7:0] clip_channel(input longint acc);
        longint whole;
        if (acc < 0) begin
            return 8'd0;
        end
        whole = acc >>> 16;
        return (whole > 255) ? 8'd255 : whole[7:0];
    endfunction

    function automatic t_pixel_out convert_pixel(input t_pixel_in px, input t_pixel_format fmt);
        t_pixel_out res;
        longint     base;
        longint     cb;
        longint     cr;
        base = scaled_luma(px.luma) + Q16_HALF;
        cb = longint'(px.chroma_blue) - CHROMA_MID;
        cr = longint'(px.chroma_red) - CHROMA_MID;
        res.red   = clip_channel(base + cr * CR_TO_RED);
        res.green = clip_channel(base - cb * CB_TO_GREEN - cr * CR_TO_GREEN);
        res.blue  = clip_channel(base + cb * CB_TO_BLUE);
        case (fmt)
            FMT_RGB565: begin
                res.packed_pixel = {8'd0, res.red[7:3], res.green[7:2], res.blue[7:3]};
            end
            FMT_RGB555: begin
                res.packed_pixel = {9'd0, res.red[7:3], res.green[7:3], res.blue[7:3]};
            end
            default: begin
                res.packed_pixel = {res.red, res.green, res.blue};
            end
        endcase
        return res;
    endfunction

    task automatic write_reg(input logic index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_PIXEL_FORMAT) begin
            cur_format = t_pixel_format'(data[1:0]);
        end
        @(posedge i_clk);
    endtask

    // The start line is left high on return so that back-to-back beats need no extra step.
    task automatic send_pixel(input t_pixel_in px);
        while (gaps_on && $urandom_range(99) < 24) begin
            start   <= 1'b0;
            i_pixel <= t_pixel_in'($urandom);
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        pending_rgb.push_back(convert_pixel(px, cur_format));
        pixels_sent++;
        format_pixels[cur_format]++;
    endtask

    task automatic stop_sending();
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_rgb.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_ycc(input int y, input int cb, input int cr);
        t_pixel_in px;
        px.luma        = y[7:0];
        px.chroma_blue = cb[7:0];
        px.chroma_red  = cr[7:0];
        send_pixel(px);
    endtask

    task automatic compare_field(input string name, input logic [23:0] want,
                                 input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%06h, got 0x%06h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_pixel_out want;
        if (i_rst_n && o_result_valid) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected result, expected none, got 0x%h", $time, o_result);
                errors++;
            end else begin
                want = pending_rgb.pop_front();
                compare_field("red", 24'(want.red), 24'(o_result.red));
                compare_field("green", 24'(want.green), 24'(o_result.green));
                compare_field("blue", 24'(want.blue), 24'(o_result.blue));
                compare_field("packed_pixel", want.packed_pixel, o_result.packed_pixel);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_reset_format();
        send_ycc(0, 0, 0);
        send_ycc(255, 255, 255);
        send_ycc(16, 128, 128);
        send_ycc(235, 128, 128);
        send_ycc(0, 128, 128);
        send_ycc(255, 128, 128);
        send_ycc(16, 0, 0);
        send_ycc(235, 255, 255);
        send_ycc(128, 255, 0);
        send_ycc(128, 0, 255);
        send_ycc(81, 90, 240);
        send_ycc(145, 54, 34);
        send_ycc(41, 240, 110);
        stop_sending();
    endtask

    task automatic test_each_format();
        t_pixel_format fmt;
        fmt = fmt.first();
        do begin
            wait_drained();
            write_reg(REG_PIXEL_FORMAT, 32'(fmt));
            send_ycc(235, 16, 240);
            send_ycc(170, 166, 16);
            send_ycc(106, 202, 222);
            stop_sending();
            fmt = fmt.next();
        end while (fmt != fmt.first());
    endtask

    // A write to an address past the register list must leave the packing unchanged.
    task automatic test_spare_address();
        wait_drained();
        write_reg(REG_PIXEL_FORMAT, 32'(FMT_RGB24));
        write_reg(REG_SPARE, 32'(FMT_RGB565));
        send_ycc(210, 16, 146);
        send_ycc(29, 255, 107);
        stop_sending();
    endtask

    task automatic test_random_stream();
        t_pixel_format plan[6];
        t_pixel_in     px;
        plan = '{FMT_XRGB32, FMT_RGB565, FMT_RGB555, FMT_RGB24, FMT_RGB565, FMT_XRGB32};
        foreach (plan[p]) begin
            wait_drained();
            write_reg(REG_PIXEL_FORMAT, {30'($urandom_range(32'h3fff_ffff)), 2'(plan[p])});
            gaps_on = (p != 2);
            for (int n = 0; n < 100; n++) begin
                if (p == 4 && n == 50) begin
                    stop_sending();
                    wait_drained();
                end
                if ($urandom_range(99) < 70) begin
                    px.luma        = 8'($urandom_range(235, 16));
                    px.chroma_blue = 8'($urandom_range(240, 16));
                    px.chroma_red  = 8'($urandom_range(240, 16));
                end else begin
                    px = t_pixel_in'($urandom);
                end
                send_pixel(px);
            end
            stop_sending();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_format();
        test_each_format();
        test_spare_address();
        test_random_stream();
        for (int n = 0; n < 200 && pending_rgb.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (pending_rgb.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_rgb.size());
            errors++;
        end
        $display("Converted %0d pixels and checked %0d results, with errors: %0d.",
                 pixels_sent, results_checked, errors);
        $display("Pixels per packing: RGB565 %0d, RGB555 %0d, RGB24 %0d, xRGB32 %0d.",
                 format_pixels[FMT_RGB565], format_pixels[FMT_RGB555],
                 format_pixels[FMT_RGB24], format_pixels[FMT_XRGB32]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: ycbcr_to_rgb_pixel_converter_core.f
sv/ycc2rgb_pkg.sv
sv/ycc2rgb_prod.sv
sv/ycc2rgb_sum.sv
sv/ycc2rgb_pack.sv
sv/ycbcr_to_rgb_pixel_converter_core.sv
tb/tb_ycbcr_to_rgb_pixel_converter_core.sv
